[hw/rtl/u8l9_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8l9_pkg
// Shared types, codes and UTF-8 / Latin-9 helpers for the repair block.
// ----------------------------------------------------------------------------
package u8l9_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] FUNC_BYTE  = 2'd0;
	localparam logic [1:0] FUNC_CODE  = 2'd1;
	localparam logic [1:0] FUNC_FLUSH = 2'd2;

	// One job for the back end: the drained held sequence, then an optional
	// code point to encode.
	typedef struct packed {
		logic [2:0]       n_held;
		logic             complete;
		logic [3:0][7:0]  held;
		logic             has_tail;
		logic [20:0]      tail_cp;
	} job_t;

	function automatic logic [20:0] latin9_cp(input logic [7:0] b);
		logic [20:0] cp;
		begin
			unique case (b)
				8'hA4: cp = 21'h020AC;
				8'hA6: cp = 21'h00160;
				8'hA8: cp = 21'h00161;
				8'hB4: cp = 21'h0017D;
				8'hB8: cp = 21'h0017E;
				8'hBC: cp = 21'h00152;
				8'hBD: cp = 21'h00153;
				8'hBE: cp = 21'h00178;
				default: cp = {13'd0, b};
			endcase
			return cp;
		end
	endfunction

	function automatic logic [2:0] utf8_len(input logic [20:0] cp);
		logic [2:0] len;
		begin
			if (cp[20:7] == '0) begin
				len = 3'd1;
			end else if (cp[20:11] == '0) begin
				len = 3'd2;
			end else if (cp[20:16] == '0) begin
				len = 3'd3;
			end else begin
				len = 3'd4;
			end
			return len;
		end
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
		logic [7:0] b;
		begin
			unique case (utf8_len(cp))
				3'd1: b = cp[7:0];
				3'd2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
				3'd3: begin
					unique case (idx)
						2'd0: b = {4'b1110, cp[15:12]};
						2'd1: b = {2'b10, cp[11:6]};
						default: b = {2'b10, cp[5:0]};
					endcase
				end
				default: begin
					unique case (idx)
						2'd0: b = {5'b11110, cp[20:18]};
						2'd1: b = {2'b10, cp[17:12]};
						2'd2: b = {2'b10, cp[11:6]};
						default: b = {2'b10, cp[5:0]};
					endcase
				end
			endcase
			return b;
		end
	endfunction

endpackage

[hw/rtl/u8l9_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8l9_in_if
// Input request channel: raw byte, code point or flush.
// ----------------------------------------------------------------------------
interface u8l9_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  data_byte;
	logic [20:0] code_point;

	modport source (output valid, output func, output data_byte, output code_point,
		input ready);
	modport sink (input valid, input func, input data_byte, input code_point,
		output ready);
endinterface

[hw/rtl/u8l9_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8l9_out_if
// Output request channel: one UTF-8 byte per request.
// ----------------------------------------------------------------------------
interface u8l9_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink (input valid, input out_byte, input last, output ready);
endinterface

[hw/rtl/u8l9_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8l9_queue
// Small job FIFO between the classifier and the byte emitter.
// ----------------------------------------------------------------------------
module u8l9_queue #(
	parameter int DEPTH = u8l9_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u8l9_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output u8l9_pkg::job_t  head,
	output logic            empty
);
	import u8l9_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full  = (count_q == (PW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end
endmodule

[hw/rtl/u8l9_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8l9_front
// Classifies requests, keeps the held sequence and issues emit jobs.
// ----------------------------------------------------------------------------
module u8l9_front (
	input  logic            clk,
	input  logic            arst_n,
	u8l9_in_if.sink         in_ch,
	input  logic            q_full,
	output logic            push,
	output u8l9_pkg::job_t  push_job
);
	import u8l9_pkg::*;

	logic [3:0][7:0] held_q;
	logic [2:0]      cnt_q;
	logic [2:0]      exp_q;

	logic       accept;
	logic       append;
	logic       drain;
	logic       open;
	logic [2:0] open_len;
	logic [7:0] b;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;
	assign b           = in_ch.data_byte;

	always_comb begin
		append   = 1'b0;
		drain    = 1'b0;
		open     = 1'b0;
		open_len = 3'd0;
		push_job.n_held   = cnt_q;
		push_job.complete = (cnt_q == exp_q);
		push_job.held     = held_q;
		push_job.has_tail = 1'b0;
		push_job.tail_cp  = '0;
		unique case (in_ch.func)
			FUNC_BYTE: begin
				if (b[7:6] == 2'b10 && cnt_q != 3'd0 && cnt_q < exp_q && cnt_q < 3'd4) begin
					append = 1'b1;
				end else begin
					drain = 1'b1;
					priority if (!b[7]) begin
						push_job.has_tail = 1'b1;
						push_job.tail_cp  = {13'd0, b};
					end else if (b[7:5] == 3'b110) begin
						open     = 1'b1;
						open_len = 3'd2;
					end else if (b[7:4] == 4'b1110) begin
						open     = 1'b1;
						open_len = 3'd3;
					end else if (b[7:3] == 5'b11110) begin
						open     = 1'b1;
						open_len = 3'd4;
					end else begin
						// stray byte: read as Latin-9
						push_job.has_tail = 1'b1;
						push_job.tail_cp  = latin9_cp(b);
					end
				end
			end
			FUNC_CODE: begin
				drain = 1'b1;
				push_job.has_tail = 1'b1;
				push_job.tail_cp  = in_ch.code_point;
			end
			FUNC_FLUSH: begin
				drain = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign push = accept && drain && (cnt_q != 3'd0 || push_job.has_tail);

	always_ff @(posedge clk) begin
		if (accept && append) begin
			held_q[cnt_q[1:0]] <= b;
		end else if (accept && open) begin
			held_q[0] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			exp_q <= 3'd0;
		end else if (accept) begin
			if (append) begin
				cnt_q <= cnt_q + 3'd1;
			end else if (open) begin
				cnt_q <= 3'd1;
				exp_q <= open_len;
			end else if (drain) begin
				cnt_q <= 3'd0;
				exp_q <= 3'd0;
			end
		end
	end
endmodule

[hw/rtl/u8l9_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8l9_back
// Expands one job into output bytes, one byte per cycle while the output is ready.
// ----------------------------------------------------------------------------
module u8l9_back (
	input  logic            clk,
	input  logic            arst_n,
	input  u8l9_pkg::job_t  head,
	input  logic            q_empty,
	output logic            pop,
	u8l9_out_if.source      out_ch
);
	import u8l9_pkg::*;

	logic [2:0]  unit_q;
	logic [1:0]  byte_q;
	logic        valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;

	logic        in_held;
	logic [7:0]  held_sel;
	logic        raw;
	logic [20:0] cp;
	logic [2:0]  len;
	logic [7:0]  cur_byte;
	logic        unit_end;
	logic        job_end;
	logic        advance;

	assign in_held  = (unit_q < head.n_held);
	assign held_sel = head.held[unit_q[1:0]];
	assign raw      = in_held && head.complete;
	assign cp       = in_held ? latin9_cp(held_sel) : head.tail_cp;
	assign len      = raw ? 3'd1 : utf8_len(cp);
	assign cur_byte = raw ? held_sel : utf8_byte(cp, byte_q);
	assign unit_end = ({1'b0, byte_q} + 3'd1 == len);
	assign job_end  = unit_end &&
		(!in_held || (unit_q + 3'd1 == head.n_held && !head.has_tail));
	assign advance  = !q_empty && (!valid_q || out_ch.ready);
	assign pop      = advance && job_end;

	assign out_ch.valid    = valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.last     = last_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= cur_byte;
			last_q     <= job_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			unit_q  <= 3'd0;
			byte_q  <= 2'd0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				if (unit_end) begin
					byte_q <= 2'd0;
					unit_q <= job_end ? 3'd0 : unit_q + 3'd1;
				end else begin
					byte_q <= byte_q + 2'd1;
				end
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end
endmodule

[hw/rtl/utf8_repair_latin9_fallback.sv]
`timescale 1ns / 1ps
// Path: a draining request is queued as a job; the emitter then registers its bytes.
// Throughput: one request per cycle in while the queue is not full; one byte
//   per cycle out while the output is ready; the job queue absorbs bursts.
// Reset: arst_n clears the held count, queue pointers and output valid; held
//   bytes and queued jobs are not cleared.
// ----------------------------------------------------------------------------
// utf8_repair_latin9_fallback
// UTF-8 pass-through; broken sequences are read as Latin-9 and re-encoded to UTF-8.
// ----------------------------------------------------------------------------
module utf8_repair_latin9_fallback #(
	parameter int QUEUE_DEPTH = u8l9_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	u8l9_in_if.sink     in_ch,
	u8l9_out_if.source  out_ch
);
	import u8l9_pkg::*;

	// Front -> queue -> back. The front decides per request what to drain and
	// what to encode; it never waits on the output unless the queue fills.
	job_t push_job;
	job_t head;
	logic push;
	logic q_full;
	logic pop;
	logic q_empty;

	// Classifier: holds the open sequence, one request per cycle if the queue has room.
	u8l9_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// Jobs waiting to be expanded into bytes.
	u8l9_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	// Emitter: walks held bytes then the tail code point, one byte a cycle while
	// the output is ready, and flags the final byte of each job.
	u8l9_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.out_ch  (out_ch)
	);
endmodule
